### design/mpcs_pkg.sv
// Package for the multi-policy command scheduler: word types, codes and sizes.
// No dependencies; every design file takes names from here by scope.
`timescale 1ns / 1ps
package mpcs_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int HIST_USERS  = 16;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int HW = $clog2(HIST_USERS);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int HCW = $clog2(HIST_USERS + 1);
  localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic [1:0] REQ_ENQ = 2'd0;
  localparam logic [1:0] REQ_NEXT = 2'd1;
  localparam logic [1:0] REQ_FIN = 2'd2;

  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_SJF = 2'd1;
  localparam logic [1:0] POL_PRIO = 2'd2;
  localparam logic [1:0] POL_RR = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_HFULL = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] cmd_tag;
    logic [7:0]  user;
    logic signed [7:0] priority_req;
    logic [31:0] run_time;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  resp_type;
    logic        granted;
    logic [15:0] out_tag;
    logic [7:0]  out_user;
    logic signed [7:0] out_priority;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  user;
    logic [7:0]  prio;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_QRD, S_QSCAN, S_HRD, S_HCMP, S_DIV, S_SHIFT, S_FRD, S_FWR, S_DONE
  } state_t;

  // Divider control between sequencer and divider.
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quo;
  } div_rsp_t;
endpackage

### design/mpcs_div.sv
// Restoring divider, one quotient bit a cycle, 48 by 16 bits.
// Depends on mpcs_pkg for the request and response structs.
`timescale 1ns / 1ps
module mpcs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mpcs_pkg::div_req_t req,
  output mpcs_pkg::div_rsp_t rsp
);
  logic [47:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [16:0] trial;

  // One shift and subtract step a cycle.
  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[15:0], q_r[47]};
    if (req.start) begin
      q_nxt = req.num; rem_nxt = '0; den_nxt = req.den;
      cnt_nxt = 6'd48; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
endmodule

### design/multi_policy_command_scheduler.sv
// Multi-policy command scheduler: one result word a request, after a scan for a next.
// Depends on mpcs_pkg and mpcs_div.
//
// The pending queue and the per-user history live in two synchronous memories.
// Enqueue, a next on an empty queue, an unknown request and a finished report
// outside shortest job first hold busy only through the done state, and the
// result word is on the ports in the cycle after. Under shortest job first a
// finished report searches the history one slot a cycle. A next request reads
// each pending entry through the read and scan states and then closes the gap
// one entry a cycle. Under shortest job first each entry also searches the
// history, a read and a compare state a slot, and a matched user with a
// nonzero count runs a divide that holds the scan until the quotient is done.
// The result appears for a single cycle with out_valid; the receiver cannot
// stall it.
// The history reset state is held by a fill count.
module multi_policy_command_scheduler (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mpcs_pkg::in_word_t   in_word,
  output logic                 out_valid,
  output mpcs_pkg::out_word_t  out_word,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_policy
);
  localparam int QW = mpcs_pkg::QW;
  localparam int HW = mpcs_pkg::HW;
  localparam int QCW = mpcs_pkg::QCW;
  localparam int HCW = mpcs_pkg::HCW;

  // Memories.
  mpcs_pkg::entry_t qmem [mpcs_pkg::QUEUE_DEPTH];
  logic [71:0]      hmem [mpcs_pkg::HIST_USERS];  // {user, total, count}
  mpcs_pkg::entry_t q_rd;
  logic [71:0]      h_rd;
  logic [QW-1:0]    q_ra, q_wa;
  logic             q_we;
  mpcs_pkg::entry_t q_wd;
  logic [HW-1:0]    h_ra, h_wa;
  logic             h_we;
  logic [71:0]      h_wd;

  always_ff @(posedge clk) begin
    if (q_we) qmem[q_wa] <= q_wd;
    q_rd <= qmem[q_ra];
  end
  always_ff @(posedge clk) begin
    if (h_we) hmem[h_wa] <= h_wd;
    h_rd <= hmem[h_ra];
  end

  mpcs_pkg::state_t state_r, state_nxt;
  mpcs_pkg::in_word_t req_r, req_nxt;
  logic [1:0]  policy_r;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic [HCW-1:0] hused_r, hused_nxt;
  logic [7:0]  last_r, last_nxt;
  logic        lastv_r, lastv_nxt;
  logic [QCW-1:0] i_r, i_nxt;     // queue scan index
  logic [HCW-1:0] j_r, j_nxt;     // history scan index
  logic [QW-1:0] best_r, best_nxt;
  mpcs_pkg::entry_t cur_r, cur_nxt, sel_r, sel_nxt;
  logic [48:0] bmean_r, bmean_nxt; // bit 48 set means no mean
  logic        found_r, found_nxt;
  logic [71:0] hrec_r, hrec_nxt;
  logic [HW-1:0] hslot_r, hslot_nxt;
  mpcs_pkg::out_word_t res_r, res_nxt;
  logic        ov_r, ov_nxt;
  mpcs_pkg::div_req_t dreq;
  mpcs_pkg::div_rsp_t drsp;
  logic [48:0] sum;
  logic        better;

  mpcs_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Next state and datapath.
  always_comb begin
    state_nxt = state_r; req_nxt = req_r; cnt_nxt = cnt_r; hused_nxt = hused_r;
    last_nxt = last_r; lastv_nxt = lastv_r; i_nxt = i_r; j_nxt = j_r;
    best_nxt = best_r; cur_nxt = cur_r; sel_nxt = sel_r; bmean_nxt = bmean_r;
    found_nxt = found_r; hrec_nxt = hrec_r; hslot_nxt = hslot_r;
    res_nxt = res_r; ov_nxt = 1'b0;
    q_ra = i_r[QW-1:0]; q_we = 1'b0; q_wa = i_r[QW-1:0]; q_wd = q_rd;
    h_ra = j_r[HW-1:0]; h_we = 1'b0; h_wa = hslot_r; h_wd = hrec_r;
    dreq = '0; sum = '0; better = 1'b0;
    case (state_r)
      mpcs_pkg::S_IDLE: begin
        if (start) begin
          req_nxt = in_word;
          res_nxt = '0;
          res_nxt.resp_type = in_word.req_type;
          i_nxt = '0; j_nxt = '0; best_nxt = '0; found_nxt = 1'b0;
          bmean_nxt = {1'b1, 48'd0};
          case (in_word.req_type)
            mpcs_pkg::REQ_ENQ: begin
              if (cnt_r >= QCW'(mpcs_pkg::QUEUE_DEPTH)) begin
                res_nxt.status = mpcs_pkg::ST_FULL;
              end else begin
                q_we = 1'b1; q_wa = cnt_r[QW-1:0];
                q_wd = {in_word.cmd_tag, in_word.user, in_word.priority_req};
                cnt_nxt = cnt_r + 1'b1;
                res_nxt.granted = 1'b1;
              end
              state_nxt = mpcs_pkg::S_DONE;
            end
            mpcs_pkg::REQ_NEXT: begin
              if (cnt_r == '0) begin
                res_nxt.status = mpcs_pkg::ST_EMPTY;
                state_nxt = mpcs_pkg::S_DONE;
              end else begin
                q_ra = '0;
                state_nxt = mpcs_pkg::S_QRD;
              end
            end
            mpcs_pkg::REQ_FIN: begin
              if (policy_r != mpcs_pkg::POL_SJF) begin
                res_nxt.granted = 1'b1;
                state_nxt = mpcs_pkg::S_DONE;
              end else begin
                h_ra = '0;
                state_nxt = mpcs_pkg::S_FRD;
              end
            end
            default: state_nxt = mpcs_pkg::S_DONE;
          endcase
        end
      end
      // Queue entry i arrives from memory.
      mpcs_pkg::S_QRD: begin
        cur_nxt = q_rd;
        if (i_r == '0) sel_nxt = q_rd;
        state_nxt = mpcs_pkg::S_QSCAN;
      end
      mpcs_pkg::S_QSCAN: begin
        case (policy_r)
          mpcs_pkg::POL_PRIO:
            better = (i_r != '0) && ($signed(cur_r.prio) > $signed(sel_r.prio));
          mpcs_pkg::POL_RR:
            better = lastv_r && !found_r && (cur_r.user != last_r);
          default: better = 1'b0;
        endcase
        if (better) begin
          best_nxt = i_r[QW-1:0]; sel_nxt = cur_r;
          if (policy_r == mpcs_pkg::POL_RR) found_nxt = 1'b1;
        end
        if (policy_r == mpcs_pkg::POL_SJF) begin
          j_nxt = '0; h_ra = '0;
          state_nxt = (hused_r == '0) ? mpcs_pkg::S_QSCAN : mpcs_pkg::S_HRD;
          if (hused_r == '0) begin
            if (i_r + 1'b1 >= cnt_r) begin
              i_nxt = QCW'(best_r); state_nxt = mpcs_pkg::S_SHIFT;
              q_ra = best_r + 1'b1;
            end else begin
              i_nxt = i_r + 1'b1; q_ra = i_r[QW-1:0] + 1'b1;
              state_nxt = mpcs_pkg::S_QRD;
            end
          end
        end else if (i_r + 1'b1 >= cnt_r) begin
          i_nxt = QCW'(better ? i_r[QW-1:0] : best_r);
          q_ra = (better ? i_r[QW-1:0] : best_r) + 1'b1;
          state_nxt = mpcs_pkg::S_SHIFT;
        end else begin
          i_nxt = i_r + 1'b1; q_ra = i_r[QW-1:0] + 1'b1;
          state_nxt = mpcs_pkg::S_QRD;
        end
      end
      // History search for the user of cur_r.
      mpcs_pkg::S_HRD: state_nxt = mpcs_pkg::S_HCMP;
      mpcs_pkg::S_HCMP: begin
        if (h_rd[71:64] == cur_r.user) begin
          if (h_rd[15:0] == '0) begin
            state_nxt = mpcs_pkg::S_DIV;
            dreq.start = 1'b0;
            // No mean: entry never wins, continue the scan.
            j_nxt = hused_r;
          end else begin
            dreq.start = 1'b1; dreq.num = h_rd[63:16]; dreq.den = h_rd[15:0];
            state_nxt = mpcs_pkg::S_DIV;
            j_nxt = '0;
          end
        end else if (j_r + 1'b1 >= hused_r) begin
          j_nxt = hused_r; state_nxt = mpcs_pkg::S_DIV;
        end else begin
          j_nxt = j_r + 1'b1; h_ra = j_r[HW-1:0] + 1'b1;
          state_nxt = mpcs_pkg::S_HRD;
        end
      end
      mpcs_pkg::S_DIV: begin
        if (j_r == hused_r || drsp.done) begin
          if (j_r != hused_r && {1'b0, drsp.quo} < bmean_r) begin
            bmean_nxt = {1'b0, drsp.quo}; best_nxt = i_r[QW-1:0]; sel_nxt = cur_r;
          end
          if (i_r + 1'b1 >= cnt_r) begin
            if (j_r != hused_r && {1'b0, drsp.quo} < bmean_r) begin
              i_nxt = i_r; q_ra = i_r[QW-1:0] + 1'b1;
            end else begin
              i_nxt = QCW'(best_r); q_ra = best_r + 1'b1;
            end
            state_nxt = mpcs_pkg::S_SHIFT;
          end else begin
            i_nxt = i_r + 1'b1; q_ra = i_r[QW-1:0] + 1'b1;
            state_nxt = mpcs_pkg::S_QRD;
          end
        end
      end
      // Close the gap: entry i+1 has been read, write it to i and read i+2.
      mpcs_pkg::S_SHIFT: begin
        if (i_r + 1'b1 >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1;
          res_nxt.granted = 1'b1; res_nxt.out_tag = sel_r.tag;
          res_nxt.out_user = sel_r.user; res_nxt.out_priority = sel_r.prio;
          if (policy_r == mpcs_pkg::POL_RR) begin
            last_nxt = sel_r.user; lastv_nxt = 1'b1;
          end
          state_nxt = mpcs_pkg::S_DONE;
        end else begin
          q_we = 1'b1; q_wa = i_r[QW-1:0]; q_wd = q_rd;
          i_nxt = i_r + 1'b1; q_ra = i_r[QW-1:0] + 2'd2;
          state_nxt = mpcs_pkg::S_SHIFT;
        end
      end
      // Finished report: search the history slot by slot.
      mpcs_pkg::S_FRD: begin
        if (j_r >= hused_r) begin
          if (hused_r >= HCW'(mpcs_pkg::HIST_USERS)) begin
            res_nxt.status = mpcs_pkg::ST_HFULL;
            state_nxt = mpcs_pkg::S_DONE;
          end else begin
            hslot_nxt = hused_r[HW-1:0]; hused_nxt = hused_r + 1'b1;
            hrec_nxt = {req_r.user, 64'd0};
            state_nxt = mpcs_pkg::S_FWR;
          end
        end else if (j_r != '0 && h_rd[71:64] == req_r.user) begin
          hslot_nxt = j_r[HW-1:0] - 1'b1; hrec_nxt = h_rd;
          state_nxt = mpcs_pkg::S_FWR;
        end else begin
          j_nxt = j_r + 1'b1; h_ra = j_r[HW-1:0];
        end
        if (j_r != '0 && j_r <= hused_r && h_rd[71:64] == req_r.user) begin
          hslot_nxt = j_r[HW-1:0] - 1'b1; hrec_nxt = h_rd;
          state_nxt = mpcs_pkg::S_FWR;
          hused_nxt = hused_r;
          res_nxt.status = mpcs_pkg::ST_OK;
        end
      end
      mpcs_pkg::S_FWR: begin
        sum = {1'b0, hrec_r[63:16]} + {17'd0, req_r.run_time};
        h_we = 1'b1; h_wa = hslot_r;
        h_wd = {hrec_r[71:64], sum[48] ? mpcs_pkg::TOTAL_MAX : sum[47:0],
                (hrec_r[15:0] == mpcs_pkg::COUNT_MAX) ? hrec_r[15:0]
                                                      : hrec_r[15:0] + 16'd1};
        res_nxt.granted = 1'b1;
        state_nxt = mpcs_pkg::S_DONE;
      end
      mpcs_pkg::S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = mpcs_pkg::S_IDLE;
      end
      default: state_nxt = mpcs_pkg::S_IDLE;
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpcs_pkg::S_IDLE; cnt_r <= '0; hused_r <= '0;
      last_r <= '0; lastv_r <= 1'b0; ov_r <= 1'b0; policy_r <= mpcs_pkg::POL_FCFS;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; hused_r <= hused_nxt;
      last_r <= last_nxt; lastv_r <= lastv_nxt; ov_r <= ov_nxt;
      if (cfg_we) policy_r <= cfg_policy;
    end
    req_r <= req_nxt; i_r <= i_nxt; j_r <= j_nxt; best_r <= best_nxt;
    cur_r <= cur_nxt; sel_r <= sel_nxt; bmean_r <= bmean_nxt; found_r <= found_nxt;
    hrec_r <= hrec_nxt; hslot_r <= hslot_nxt; res_r <= res_nxt;
  end

  // Outputs.
  always_comb begin
    busy = (state_r != mpcs_pkg::S_IDLE);
    out_valid = ov_r;
    out_word = res_r;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(mpcs_pkg::QUEUE_DEPTH)) else $error("queue count overflow");
  a_hused: assert property (@(posedge clk) disable iff (!rst_n)
    hused_r <= HCW'(mpcs_pkg::HIST_USERS)) else $error("history count overflow");
  a_ov: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted word not taken");
endmodule
